// File: design/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometer pressure/temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // Accept-to-strobe latency in clock cycles
  localparam int unsigned LATENCY = 9;

  // Calibration register indexes
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // Calibration reset values
  localparam logic [15:0] C1_RESET = 16'd40127;
  localparam logic [15:0] C2_RESET = 16'd36924;
  localparam logic [15:0] C3_RESET = 16'd23317;
  localparam logic [15:0] C4_RESET = 16'd23282;
  localparam logic [15:0] C5_RESET = 16'd33464;
  localparam logic [15:0] C6_RESET = 16'd28312;

  // Temperature thresholds, 0.01 degC
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;
  localparam logic signed [19:0] TEMP_LOW = -20'sd1500;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } cal_t;

  // First-order terms
  typedef struct packed {
    logic [23:0] d1;
    logic [19:0] temp;   // signed
    logic [17:0] t2;     // unsigned
    logic [39:0] off;    // signed
    logic [39:0] sens;   // signed
  } base_t;

  // Fully corrected terms
  typedef struct packed {
    logic [23:0] d1;
    logic [19:0] temp;   // signed
    logic [39:0] off;    // signed
    logic [39:0] sens;   // signed
  } comp_t;

endpackage

// File: design/bptc_coef.sv
// ----------------------------------------------------------------------------
// bptc_coef
// First-order stages: dT, the four dT products, then TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
module bptc_coef import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cal_t        cal,
  input  logic        in_valid,
  input  logic [23:0] d1,
  input  logic [23:0] d2,
  output logic        out_valid,
  output base_t       out
);

  // stage 1
  logic               v1;
  logic [23:0]        d1_s1;
  logic signed [24:0] dt;

  // stage 2
  logic               v2;
  logic [23:0]        d1_s2;
  logic signed [41:0] p6;
  logic signed [41:0] p4;
  logic signed [41:0] p3;
  logic signed [49:0] pdd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d1_s1 <= d1;
    dt    <= $signed({1'b0, d2}) - $signed({1'b0, cal.c5, 8'b0});

    d1_s2 <= d1_s1;
    p6    <= dt * $signed({1'b0, cal.c6});
    p4    <= dt * $signed({1'b0, cal.c4});
    p3    <= dt * $signed({1'b0, cal.c3});
    pdd   <= dt * dt;

    out.d1   <= d1_s2;
    out.temp <= {p6[41], p6[41:23]} + TEMP_REF;
    out.t2   <= pdd[48:31];
    out.off  <= {{5{p4[41]}}, p4[41:7]} + {8'b0, cal.c2, 16'b0};
    out.sens <= {{6{p3[41]}}, p3[41:8]} + {9'b0, cal.c1, 15'b0};
  end

endmodule

// File: design/bptc_corr.sv
// ----------------------------------------------------------------------------
// bptc_corr
// Second-order stages: squares of the temperature deltas, OFF2/SENS2,
// then the corrected TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bptc_corr import bptc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  base_t in,
  output logic  out_valid,
  output comp_t out
);

  logic signed [20:0] tm;
  logic signed [20:0] tl;
  logic signed [41:0] sq_m;
  logic signed [41:0] sq_l;
  logic [40:0]        a5;
  logic [40:0]        b7;
  logic [40:0]        b11;

  // stage 4
  logic        v4;
  base_t       b4;
  logic [36:0] a4;
  logic [36:0] q4;
  logic        lt4;
  logic        vlt4;

  // stage 5
  logic        v5;
  base_t       b5;
  logic [40:0] off2;
  logic [40:0] sens2;
  logic        lt5;

  assign tm   = $signed({in.temp[19], in.temp}) - 21'sd2000;
  assign tl   = $signed({in.temp[19], in.temp}) + 21'sd1500;
  assign sq_m = tm * tm;
  assign sq_l = tl * tl;

  assign a5  = {4'b0, a4} + {2'b0, a4, 2'b0};
  assign b7  = {1'b0, q4, 3'b0} - {4'b0, q4};
  assign b11 = {1'b0, q4, 3'b0} + {3'b0, q4, 1'b0} + {4'b0, q4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    b4   <= in;
    a4   <= sq_m[36:0];
    q4   <= sq_l[36:0];
    lt4  <= $signed(in.temp) < TEMP_REF;
    vlt4 <= $signed(in.temp) < TEMP_LOW;

    // each term floored on its own, as specified
    b5    <= b4;
    lt5   <= lt4;
    off2  <= lt4 ? ({1'b0, a5[40:1]} + (vlt4 ? b7 : 41'd0)) : 41'd0;
    sens2 <= lt4 ? ({2'b0, a5[40:2]} + (vlt4 ? {1'b0, b11[40:1]} : 41'd0)) : 41'd0;

    out.d1   <= b5.d1;
    out.temp <= lt5 ? (b5.temp - {2'b0, b5.t2}) : b5.temp;
    out.off  <= b5.off - off2[39:0];
    out.sens <= b5.sens - sens2[39:0];
  end

endmodule

// File: design/bptc_pres.sv
// ----------------------------------------------------------------------------
// bptc_pres
// Pressure stages: D1*SENS as two partial products, recombine, then
// subtract OFF and scale to 0.01 mbar. Last stage is the result register.
// ----------------------------------------------------------------------------
module bptc_pres import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  comp_t       in,
  output logic        done,
  output logic [31:0] pressure,
  output logic [19:0] temperature
);

  // stage 7
  logic               v7;
  logic [43:0]        pp_lo;
  logic signed [44:0] pp_hi;
  logic [39:0]        off7;
  logic [19:0]        temp7;

  // stage 8
  logic               v8;
  logic [64:0]        prod;
  logic [39:0]        off8;
  logic [19:0]        temp8;

  logic [44:0]        diff;

  assign diff = {prod[64], prod[64:21]} - {{5{off8[39]}}, off8};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v7   <= in_valid;
      v8   <= v7;
      done <= v8;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo <= in.d1 * in.sens[19:0];
    pp_hi <= $signed({1'b0, in.d1}) * $signed(in.sens[39:20]);
    off7  <= in.off;
    temp7 <= in.temp;

    prod  <= {pp_hi, 20'b0} + {21'b0, pp_lo};
    off8  <= off7;
    temp8 <= temp7;

    // shifted result spans 30 bits, so the 32-bit range always holds it
    pressure    <= {{2{diff[44]}}, diff[44:15]};
    temperature <= temp8;
  end

endmodule

// File: design/baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Second-order barometer compensation: raw D1/D2 conversions in, pressure in
// 0.01 mbar and temperature in 0.01 degC out.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock while busy is low, and results
// appear on done in request order. The datapath has nine register stages
// (dT, products, first-order terms, squares, second-order terms, corrected
// terms, two-part D1*SENS multiply, recombine, final scale). Results cannot
// be held off, so there is no backpressure and busy is high only during
// reset and the first cycle after rst drops. Calibration writes are always
// accepted and take effect on the next request; write them only when no
// request is in flight. Writes to indexes past the sixth are dropped.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] raw_pressure,
  input  logic [23:0] raw_temperature,
  output logic        done,
  output logic [31:0] pressure_centi_mbar,
  output logic [19:0] temperature_centi_deg,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cal_t  cal;
  logic  base_valid;
  base_t base;
  logic  comp_valid;
  comp_t comp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.c1 <= C1_RESET;
      cal.c2 <= C2_RESET;
      cal.c3 <= C3_RESET;
      cal.c4 <= C4_RESET;
      cal.c5 <= C5_RESET;
      cal.c6 <= C6_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (start && !busy),
    .d1        (raw_pressure),
    .d2        (raw_temperature),
    .out_valid (base_valid),
    .out       (base)
  );

  bptc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (base_valid),
    .in        (base),
    .out_valid (comp_valid),
    .out       (comp)
  );

  bptc_pres u_pres (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (comp_valid),
    .in          (comp),
    .done        (done),
    .pressure    (pressure_centi_mbar),
    .temperature (temperature_centi_deg)
  );

endmodule

// File: design/bptc_checker.sv
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks for the compensation block: fixed latency, busy outside
// reset and result range.
// ----------------------------------------------------------------------------
module bptc_checker import bptc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] pressure_centi_mbar
);

  // every request yields a result after the fixed latency
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request without result");

  // no result without a matching request
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // busy must be low whenever rst and its past value are both low
  a_busy_reset: assert property (@(posedge clk)
    (!rst && $past(!rst)) |-> !busy)
    else $error("busy outside reset");

  // compensated pressure never needs more than 30 signed bits
  a_press_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pressure_centi_mbar[31:29] == 3'b000 ||
              pressure_centi_mbar[31:29] == 3'b111))
    else $error("pressure out of datapath range");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .start               (start),
  .busy                (busy),
  .done                (done),
  .pressure_centi_mbar (pressure_centi_mbar)
);
